### sv/rpm_pkg.sv
// rpm_pkg: shared types, field widths and parameter defaults of the
// refinement projection mac unit; no dependencies
`default_nettype none

package rpm_pkg;

    localparam int MAX_CHILDREN_DEF   = 8;
    localparam int MAX_NODES_DEF      = 32;
    localparam int MAX_COMPONENTS_DEF = 4;

    localparam int OP_W     = 2;
    localparam int CHILD_W  = 3;
    localparam int NODE_W   = 5;
    localparam int COMP_W   = 2;
    localparam int COEFF_W  = 18;
    localparam int COORD_W  = 32;
    localparam int NIU_W    = 6;
    localparam int PROD_W   = COEFF_W + COORD_W;
    localparam int ACC_W    = 48;
    localparam int FRAC_W   = 16;
    localparam int RESULT_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_WR_COEFF = 2'd0,
        OP_WR_COORD = 2'd1,
        OP_COMPUTE  = 2'd2,
        OP_NOP      = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clear;
        logic issue;
    } t_dp_ctl;

    typedef struct packed {
        logic busy;
    } t_dp_sts;

endpackage

`default_nettype wire

### sv/rpm_if.sv
// rpm_if: valid/ready channel interfaces for input items, results and the
// configuration write; depends on rpm_pkg
`default_nettype none

interface rpm_in_if import rpm_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           op;
    logic [CHILD_W-1:0]        child;
    logic [NODE_W-1:0]         node;
    logic [NODE_W-1:0]         term_node;
    logic [COMP_W-1:0]         component;
    logic signed [COEFF_W-1:0] coeff;
    logic signed [COORD_W-1:0] coord;

    modport source (output valid, op, child, node, term_node, component, coeff, coord,
                    input ready);
    modport sink   (input valid, op, child, node, term_node, component, coeff, coord,
                    output ready);
endinterface

interface rpm_out_if import rpm_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [RESULT_W-1:0] refined_value;
    logic                       saturated;

    modport source (output valid, refined_value, saturated, input ready);
    modport sink   (input valid, refined_value, saturated, output ready);
endinterface

interface rpm_cfg_if import rpm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [NIU_W-1:0] nodes_in_use;

    modport source (output valid, nodes_in_use, input ready);
    modport sink   (input valid, nodes_in_use, output ready);
endinterface

`default_nettype wire

### sv/rpm_ram.sv
// rpm_ram: generic simple dual-port ram, one write and one registered read
// port; no dependencies
`default_nettype none

module rpm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### sv/rpm_datapath.sv
// rpm_datapath: shared multiply-accumulate unit with 48-bit accumulator and
// 32-bit saturation; depends on rpm_pkg
`default_nettype none

module rpm_datapath import rpm_pkg::*; (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_dp_ctl                    i_ctl,
    input  wire logic [COEFF_W-1:0]         i_coeff,
    input  wire logic [COORD_W-1:0]         i_coord,
    output t_dp_sts                         o_sts,
    output logic signed [RESULT_W-1:0]      o_value,
    output logic                            o_sat
);

    logic                     r_v_rd;
    logic                     r_v_mul;
    logic signed [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]         r_acc;
    logic [ACC_W-1:0]         w_term;
    logic                     w_fits;

    // floor shift of the product, sign extended to accumulator width
    assign w_term = {{(ACC_W - PROD_W + FRAC_W){r_prod[PROD_W-1]}}, r_prod[PROD_W-1:FRAC_W]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_rd  <= 1'b0;
            r_v_mul <= 1'b0;
            r_acc   <= '0;
        end else begin
            r_v_rd  <= i_ctl.issue;
            r_v_mul <= r_v_rd;
            if (i_ctl.clear) begin
                r_acc <= '0;
            end else if (r_v_mul) begin
                r_acc <= r_acc + w_term;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= $signed(i_coeff) * $signed(i_coord);
    end

    assign w_fits = (r_acc[ACC_W-1:RESULT_W-1] == '0) || (r_acc[ACC_W-1:RESULT_W-1] == '1);

    always_comb begin
        o_sat = !w_fits;
        if (w_fits) begin
            o_value = $signed(r_acc[RESULT_W-1:0]);
        end else if (r_acc[ACC_W-1]) begin
            o_value = {1'b1, {(RESULT_W-1){1'b0}}};
        end else begin
            o_value = {1'b0, {(RESULT_W-1){1'b1}}};
        end
    end

    assign o_sts.busy = r_v_rd | r_v_mul;

endmodule

`default_nettype wire

### sv/refinement_projection_mac_unit.sv
// refinement_projection_mac_unit: table writes are taken while idle; a compute runs n macs,
// n = min(nodes_in_use, MAX_NODES), one mac per cycle through the ram read ports, multiplier
// stage and accumulator, and takes no new item until its result is loaded for output
// an out-of-range or zero-length compute skips the macs; a waiting result stalls the next one
// reset: synchronous active low, clears control, accumulator and nodes_in_use (to 1);
// the coefficient and parent rams are undefined until written, no clearing pass
`default_nettype none

module refinement_projection_mac_unit import rpm_pkg::*; #(
    parameter int MAX_CHILDREN   = MAX_CHILDREN_DEF,
    parameter int MAX_NODES      = MAX_NODES_DEF,
    parameter int MAX_COMPONENTS = MAX_COMPONENTS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rpm_in_if.sink    i_in,
    rpm_out_if.source o_out,
    rpm_cfg_if.sink   i_cfg
);

    localparam int CDEPTH = MAX_CHILDREN * MAX_NODES * MAX_NODES;
    localparam int PDEPTH = MAX_NODES * MAX_COMPONENTS;
    localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
    localparam int PAW    = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
    localparam int NW     = $clog2(MAX_NODES + 1);

    t_state                     r_state, n_state;
    logic [CAW-1:0]             r_caddr, n_caddr;
    logic [PAW-1:0]             r_paddr, n_paddr;
    logic [NW-1:0]              r_rem, n_rem;
    logic [NIU_W-1:0]           r_nodes;
    logic                       r_out_valid, n_out_valid;
    logic signed [RESULT_W-1:0] r_out_value;
    logic                       r_out_sat;
    logic                       w_load;
    logic                       w_accept;
    t_op                        w_op;
    logic                       w_child_ok, w_node_ok, w_term_ok, w_comp_ok;
    logic [NW-1:0]              w_len;
    logic                       w_coef_we, w_par_we;
    logic [CAW-1:0]             w_coef_waddr, w_cbase;
    logic [PAW-1:0]             w_par_waddr;
    logic [COEFF_W-1:0]         w_coef_rd;
    logic [COORD_W-1:0]         w_par_rd;
    t_dp_ctl                    w_ctl;
    t_dp_sts                    w_sts;
    logic signed [RESULT_W-1:0] w_value;
    logic                       w_sat;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_op        = t_op'(i_in.op);

    assign w_child_ok = int'(i_in.child) < MAX_CHILDREN;
    assign w_node_ok  = int'(i_in.node) < MAX_NODES;
    assign w_term_ok  = int'(i_in.term_node) < MAX_NODES;
    assign w_comp_ok  = int'(i_in.component) < MAX_COMPONENTS;

    assign w_len = (int'(r_nodes) > MAX_NODES) ? NW'(MAX_NODES) : NW'(r_nodes);

    assign w_cbase      = CAW'((int'(i_in.child) * MAX_NODES + int'(i_in.node)) * MAX_NODES);
    assign w_coef_waddr = w_cbase + CAW'(i_in.term_node);
    assign w_par_waddr  = PAW'(int'(i_in.node) * MAX_COMPONENTS + int'(i_in.component));
    assign w_coef_we    = w_accept && (w_op == OP_WR_COEFF) && w_child_ok && w_node_ok
                          && w_term_ok;
    assign w_par_we     = w_accept && (w_op == OP_WR_COORD) && w_node_ok && w_comp_ok;

    rpm_ram #(.WIDTH(COEFF_W), .DEPTH(CDEPTH)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_coef_we),
        .i_waddr (w_coef_waddr),
        .i_wdata (i_in.coeff),
        .i_raddr (r_caddr),
        .o_rdata (w_coef_rd)
    );

    rpm_ram #(.WIDTH(COORD_W), .DEPTH(PDEPTH)) u_par_ram (
        .i_clk   (i_clk),
        .i_we    (w_par_we),
        .i_waddr (w_par_waddr),
        .i_wdata (i_in.coord),
        .i_raddr (r_paddr),
        .o_rdata (w_par_rd)
    );

    rpm_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_coeff (w_coef_rd),
        .i_coord (w_par_rd),
        .o_sts   (w_sts),
        .o_value (w_value),
        .o_sat   (w_sat)
    );

    always_comb begin
        n_state     = r_state;
        n_caddr     = r_caddr;
        n_paddr     = r_paddr;
        n_rem       = r_rem;
        n_out_valid = r_out_valid && !o_out.ready;
        w_ctl       = '0;
        w_load      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (w_op == OP_COMPUTE)) begin
                    w_ctl.clear = 1'b1;
                    n_caddr     = w_cbase;
                    n_paddr     = PAW'(i_in.component);
                    n_rem       = w_len;
                    if (w_child_ok && w_node_ok && w_comp_ok && (w_len != '0)) begin
                        n_state = S_RUN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_RUN: begin
                w_ctl.issue = 1'b1;
                n_caddr     = r_caddr + CAW'(1);
                n_paddr     = r_paddr + PAW'(MAX_COMPONENTS);
                n_rem       = r_rem - NW'(1);
                if (r_rem == NW'(1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!w_sts.busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    w_load      = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_nodes     <= NIU_W'(1);
            r_rem       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_rem       <= n_rem;
            if (i_cfg.valid && i_cfg.ready) begin
                r_nodes <= i_cfg.nodes_in_use;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_caddr <= n_caddr;
        r_paddr <= n_paddr;
        if (w_load) begin
            r_out_value <= w_value;
            r_out_sat   <= w_sat;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.refined_value = r_out_value;
    assign o_out.saturated     = r_out_sat;

    // no mac may be in flight once the sequencer is back to idle
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_sts.busy)
        else $error("mac pipeline busy while idle");

    // every issued mac has a remaining count behind it
    a_issue_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.issue |-> (r_rem != '0))
        else $error("mac issued past the dot product length");

    // finishing a compute always presents a result
    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_out_valid || o_out.ready)) |=> r_out_valid)
        else $error("compute finished without a result");

    // a clipped result sits at one of the range limits
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_sat) |->
        (r_out_value == 32'sh7fffffff || r_out_value == 32'sh80000000))
        else $error("saturated result not at a limit");

endmodule

`default_nettype wire
